### sv/ukol_pkg.sv
`default_nettype none

package ukol_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned QUEUE_DEPTH  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_DELETE = 3'd1,
    OP_INSERT = 3'd2,
    OP_SEARCH = 3'd3,
    OP_UPDATE = 3'd4,
    OP_DUMP   = 3'd5
  } op_code_e;

  typedef enum logic [2:0] {
    CMD_APPEND,
    CMD_DELETE,
    CMD_INSERT,
    CMD_SEARCH,
    CMD_UPDATE,
    CMD_DUMP,
    CMD_NONE
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e             kind;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] target;
    logic             tgt_in_range;
    logic [POS_W-1:0] tgt_pos;
  } cmd_t;

endpackage

`default_nettype wire

### sv/ukol_front.sv
`default_nettype none

module ukol_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [ukol_pkg::OP_W-1:0]         op_i,
  input  wire logic [ukol_pkg::KEY_W-1:0]        key_i,
  input  wire logic [ukol_pkg::KEY_W-1:0]        target_i,
  output logic                                   cmd_valid_o,
  output ukol_pkg::cmd_t                         cmd_o,
  input  wire logic                              cmd_pop_i
);

  localparam int unsigned PTR_W  = $clog2(ukol_pkg::QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(ukol_pkg::QUEUE_DEPTH + 1);

  ukol_pkg::cmd_t     slot_q [ukol_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic               full, empty, push, pop;
  ukol_pkg::cmd_t     dec;

  // classify the op and pre-check the insert position range
  always_comb begin
    dec = '0;
    dec.key          = key_i;
    dec.target       = target_i;
    dec.tgt_in_range = !target_i[ukol_pkg::KEY_W-1]
                       && (target_i[ukol_pkg::KEY_W-1:ukol_pkg::POS_W] == '0)
                       && (target_i[ukol_pkg::POS_W-1:0] != '0);
    dec.tgt_pos      = target_i[ukol_pkg::POS_W-1:0];
    unique case (op_i)
      ukol_pkg::OP_APPEND: dec.kind = ukol_pkg::CMD_APPEND;
      ukol_pkg::OP_DELETE: dec.kind = ukol_pkg::CMD_DELETE;
      ukol_pkg::OP_INSERT: dec.kind = ukol_pkg::CMD_INSERT;
      ukol_pkg::OP_SEARCH: dec.kind = ukol_pkg::CMD_SEARCH;
      ukol_pkg::OP_UPDATE: dec.kind = ukol_pkg::CMD_UPDATE;
      ukol_pkg::OP_DUMP:   dec.kind = ukol_pkg::CMD_DUMP;
      default:             dec.kind = ukol_pkg::CMD_NONE;
    endcase
  end

  assign full        = (fill_q == FILL_W'(ukol_pkg::QUEUE_DEPTH));
  assign empty       = (fill_q == '0);
  assign in_stall_o  = full;
  assign push        = in_valid_i && !full;
  assign pop         = cmd_pop_i && !empty;
  assign cmd_valid_o = !empty;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = FILL_W'(fill_q + 1'b1);
    end else if (pop && !push) begin
      fill_d = FILL_W'(fill_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

endmodule

`default_nettype wire

### sv/ukol_engine.sv
`default_nettype none

module ukol_engine #(
  parameter int unsigned CAPACITY = ukol_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cmd_valid_i,
  input  wire ukol_pkg::cmd_t                    cmd_i,
  output logic                                   cmd_pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [ukol_pkg::STATUS_W-1:0]          status_o,
  output logic [ukol_pkg::POS_W-1:0]             position_o,
  output logic [ukol_pkg::KEY_W-1:0]             entry_key_o,
  output logic                                   has_entry_o,
  output logic [ukol_pkg::POS_W-1:0]             count_o,
  output logic                                   last_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned KW    = ukol_pkg::KEY_W;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SCAN      = 8'b0000_0010,
    S_DECIDE    = 8'b0000_0100,
    S_SHIFT     = 8'b0000_1000,
    S_FINISH    = 8'b0001_0000,
    S_RESULT    = 8'b0010_0000,
    S_DUMP_RD   = 8'b0100_0000,
    S_DUMP_WAIT = 8'b1000_0000
  } state_e;

  logic [KW-1:0]     mem [CAPACITY];
  logic [KW-1:0]     rdata_q;
  logic              mem_re, mem_we;
  logic [IDX_W-1:0]  mem_raddr, mem_waddr;
  logic [KW-1:0]     mem_wdata;

  state_e            state_q, state_d;
  ukol_pkg::cmd_t    cmd_q, cmd_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic              rd_pend_q, rd_pend_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              fk_q, fk_d, ft_q, ft_d;
  logic [CNT_W-1:0]  fk_idx_q, fk_idx_d, ft_idx_q, ft_idx_d;
  logic [CNT_W-1:0]  src_q, src_d;
  logic [CNT_W-1:0]  mv_left_q, mv_left_d;
  logic              mv_pend_q, mv_pend_d;
  logic [CNT_W-1:0]  mv_dst_q, mv_dst_d;
  logic [CNT_W-1:0]  ins_p_q, ins_p_d;

  ukol_pkg::status_e res_status_q, res_status_d;
  logic [CNT_W-1:0]  res_pos_q, res_pos_d;
  logic [KW-1:0]     res_key_q, res_key_d;
  logic              res_has_q, res_has_d;

  logic              out_valid_q, out_valid_d;
  logic [ukol_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [CNT_W-1:0]  out_pos_q, out_pos_d;
  logic [KW-1:0]     out_key_q, out_key_d;
  logic              out_has_q, out_has_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic              out_last_q, out_last_d;

  logic              out_free, is_full, pos_bad, dump_last;
  logic [CNT_W-1:0]  p_new;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_full   = (count_q == CNT_W'(CAPACITY));
  assign pos_bad   = !cmd_i.tgt_in_range
                     || (cmd_i.tgt_pos > ukol_pkg::POS_W'(count_q) + ukol_pkg::POS_W'(1));
  assign p_new     = CNT_W'(cmd_i.tgt_pos - ukol_pkg::POS_W'(1));
  assign dump_last = (CNT_W'(ptr_q + 1'b1) == count_q);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    rd_pend_d    = rd_pend_q;
    rd_idx_d     = rd_idx_q;
    fk_d         = fk_q;
    fk_idx_d     = fk_idx_q;
    ft_d         = ft_q;
    ft_idx_d     = ft_idx_q;
    src_d        = src_q;
    mv_left_d    = mv_left_q;
    mv_pend_d    = mv_pend_q;
    mv_dst_d     = mv_dst_q;
    ins_p_d      = ins_p_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_key_d    = res_key_q;
    res_has_d    = res_has_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_key_d    = out_key_q;
    out_has_d    = out_has_q;
    out_cnt_d    = out_cnt_q;
    out_last_d   = out_last_q;
    cmd_pop_o    = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = ptr_q[IDX_W-1:0];
    mem_we       = 1'b0;
    mem_waddr    = count_q[IDX_W-1:0];
    mem_wdata    = cmd_q.key;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o    = 1'b1;
          cmd_d        = cmd_i;
          fk_d         = 1'b0;
          ft_d         = 1'b0;
          ptr_d        = '0;
          rd_pend_d    = 1'b0;
          ins_p_d      = p_new;
          res_status_d = ukol_pkg::ST_OK;
          res_pos_d    = '0;
          res_key_d    = '0;
          res_has_d    = 1'b0;
          priority if (cmd_i.kind == ukol_pkg::CMD_NONE) begin
            state_d = S_RESULT;
          end else if (cmd_i.kind == ukol_pkg::CMD_DUMP) begin
            state_d = (count_q == '0) ? S_RESULT : S_DUMP_RD;
          end else if (cmd_i.kind == ukol_pkg::CMD_INSERT && pos_bad) begin
            res_status_d = ukol_pkg::ST_BADPOS;
            state_d      = S_RESULT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (ptr_q != count_q) begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_idx_d  = ptr_q;
          ptr_d     = CNT_W'(ptr_q + 1'b1);
        end else begin
          rd_pend_d = 1'b0;
        end
        if (rd_pend_q) begin
          if (rdata_q == cmd_q.key) begin
            fk_d     = 1'b1;
            fk_idx_d = rd_idx_q;
          end
          if (rdata_q == cmd_q.target) begin
            ft_d     = 1'b1;
            ft_idx_d = rd_idx_q;
          end
        end else if (ptr_q == count_q) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_d   = S_RESULT;
        mv_pend_d = 1'b0;
        unique case (cmd_q.kind)
          ukol_pkg::CMD_APPEND: begin
            priority if (fk_q) begin
              res_status_d = ukol_pkg::ST_DUP;
            end else if (is_full) begin
              res_status_d = ukol_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_q[IDX_W-1:0];
              count_d   = CNT_W'(count_q + 1'b1);
              res_pos_d = CNT_W'(count_q + 1'b1);
              res_key_d = cmd_q.key;
              res_has_d = 1'b1;
            end
          end
          ukol_pkg::CMD_DELETE: begin
            if (!fk_q) begin
              res_status_d = ukol_pkg::ST_NOTFOUND;
            end else begin
              src_d     = CNT_W'(fk_idx_q + 1'b1);
              mv_left_d = CNT_W'(count_q - fk_idx_q - 1'b1);
              res_pos_d = CNT_W'(fk_idx_q + 1'b1);
              res_key_d = cmd_q.key;
              res_has_d = 1'b1;
              state_d   = S_SHIFT;
            end
          end
          ukol_pkg::CMD_INSERT: begin
            priority if (fk_q) begin
              res_status_d = ukol_pkg::ST_DUP;
            end else if (is_full) begin
              res_status_d = ukol_pkg::ST_FULL;
            end else begin
              src_d     = CNT_W'(count_q - 1'b1);
              mv_left_d = CNT_W'(count_q - ins_p_q);
              res_pos_d = CNT_W'(ins_p_q + 1'b1);
              res_key_d = cmd_q.key;
              res_has_d = 1'b1;
              state_d   = S_SHIFT;
            end
          end
          ukol_pkg::CMD_SEARCH: begin
            if (!fk_q) begin
              res_status_d = ukol_pkg::ST_NOTFOUND;
            end else begin
              res_pos_d = CNT_W'(fk_idx_q + 1'b1);
              res_key_d = cmd_q.key;
              res_has_d = 1'b1;
            end
          end
          ukol_pkg::CMD_UPDATE: begin
            priority if (fk_q) begin
              res_status_d = ukol_pkg::ST_DUP;
            end else if (!ft_q) begin
              res_status_d = ukol_pkg::ST_NOTFOUND;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = ft_idx_q[IDX_W-1:0];
              res_pos_d = CNT_W'(ft_idx_q + 1'b1);
              res_key_d = cmd_q.key;
              res_has_d = 1'b1;
            end
          end
          default: begin
            res_status_d = ukol_pkg::ST_OK;
          end
        endcase
      end

      S_SHIFT: begin
        if (mv_left_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = src_q[IDX_W-1:0];
          mv_pend_d = 1'b1;
          mv_left_d = CNT_W'(mv_left_q - 1'b1);
          if (cmd_q.kind == ukol_pkg::CMD_INSERT) begin
            mv_dst_d = CNT_W'(src_q + 1'b1);
            src_d    = CNT_W'(src_q - 1'b1);
          end else begin
            mv_dst_d = CNT_W'(src_q - 1'b1);
            src_d    = CNT_W'(src_q + 1'b1);
          end
        end else begin
          mv_pend_d = 1'b0;
        end
        if (mv_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = mv_dst_q[IDX_W-1:0];
          mem_wdata = rdata_q;
        end else if (mv_left_q == '0) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        state_d = S_RESULT;
        if (cmd_q.kind == ukol_pkg::CMD_INSERT) begin
          mem_we    = 1'b1;
          mem_waddr = ins_p_q[IDX_W-1:0];
          count_d   = CNT_W'(count_q + 1'b1);
        end else begin
          count_d   = CNT_W'(count_q - 1'b1);
        end
      end

      S_RESULT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = res_has_q ? res_pos_q : '0;
          out_key_d    = res_has_q ? res_key_q : '0;
          out_has_d    = res_has_q;
          out_cnt_d    = count_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_DUMP_RD: begin
        mem_re  = 1'b1;
        state_d = S_DUMP_WAIT;
      end

      S_DUMP_WAIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ukol_pkg::ST_OK;
          out_pos_d    = CNT_W'(ptr_q + 1'b1);
          out_key_d    = rdata_q;
          out_has_d    = 1'b1;
          out_cnt_d    = count_q;
          out_last_d   = dump_last;
          if (dump_last) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = CNT_W'(ptr_q + 1'b1);
            state_d = S_DUMP_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_pend_q   <= 1'b0;
      mv_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_pend_q   <= rd_pend_d;
      mv_pend_q   <= mv_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    ptr_q        <= ptr_d;
    rd_idx_q     <= rd_idx_d;
    fk_q         <= fk_d;
    fk_idx_q     <= fk_idx_d;
    ft_q         <= ft_d;
    ft_idx_q     <= ft_idx_d;
    src_q        <= src_d;
    mv_left_q    <= mv_left_d;
    mv_dst_q     <= mv_dst_d;
    ins_p_q      <= ins_p_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_key_q    <= res_key_d;
    res_has_q    <= res_has_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_key_q    <= out_key_d;
    out_has_q    <= out_has_d;
    out_cnt_q    <= out_cnt_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign position_o  = ukol_pkg::POS_W'(out_pos_q);
  assign entry_key_o = out_key_q;
  assign has_entry_o = out_has_q;
  assign count_o     = ukol_pkg::POS_W'(out_cnt_q);
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

### sv/unique_key_ordered_list.sv
// Ordered table of unique signed 32-bit keys with append, delete, insert,
// search, update and dump operations.
// Input channel: in_valid_i / in_stall_o with op_i, key_i, target_i. A
// transfer happens on a rising edge with valid high and stall low. A two-entry
// command queue takes transfers while the table engine is busy; stall rises
// only when that queue is full.
// Output channel: out_valid_o / out_stall_i with status_o, position_o,
// entry_key_o, has_entry_o, count_o, last_o. Every op gives one result with
// last_o set; dump gives one result per entry (one with has_entry_o low when
// the table is empty), last_o marking the final one.
// The engine scans the table through its single memory read port one entry
// per cycle, then decides the op; delete and insert then shift the entries
// behind the position one at a time before the result. Dump reads one entry
// and issues its result before reading the next. An unused op, a bad insert
// position or a dump of an empty table goes to the result without a scan. One
// op runs at a time; the next starts the cycle after the last result is issued.
// While out_stall_i is high with a valid result, the result register holds
// and the engine waits at its next result; the queue keeps taking transfers
// until it is full. Reset empties the table (count zero) and the queue; the key
// memory is not cleared and entries beyond the count are never read.
`default_nettype none

module unique_key_ordered_list #(
  parameter int unsigned CAPACITY = ukol_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [ukol_pkg::OP_W-1:0]         op_i,
  input  wire logic signed [ukol_pkg::KEY_W-1:0] key_i,
  input  wire logic signed [ukol_pkg::KEY_W-1:0] target_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [ukol_pkg::STATUS_W-1:0]          status_o,
  output logic [ukol_pkg::POS_W-1:0]             position_o,
  output logic signed [ukol_pkg::KEY_W-1:0]      entry_key_o,
  output logic                                   has_entry_o,
  output logic [ukol_pkg::POS_W-1:0]             count_o,
  output logic                                   last_o
);

  logic                          cmd_valid;
  logic                          cmd_pop;
  ukol_pkg::cmd_t                cmd;
  logic [ukol_pkg::KEY_W-1:0]    entry_key;

  ukol_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .key_i       ($unsigned(key_i)),
    .target_i    ($unsigned(target_i)),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ukol_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .position_o  (position_o),
    .entry_key_o (entry_key),
    .has_entry_o (has_entry_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

  assign entry_key_o = $signed(entry_key);

endmodule

`default_nettype wire
